// ===== hw/rtl/deq_pkg.sv =====
// Shared definitions for the double-ended queue: sizes, command and status codes,
// the controller/datapath command and status structs, and ring-position helpers.
// No dependencies.
package deq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef logic [CMD_W-1:0]        command_t;
  typedef logic [STATUS_W-1:0]     status_t;
  typedef logic signed [DATA_W-1:0] element_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OCC_W-1:0]        occ_t;

  localparam command_t CMD_PUSH_RIGHT = 3'd0;
  localparam command_t CMD_PUSH_LEFT  = 3'd1;
  localparam command_t CMD_POP_LEFT   = 3'd2;
  localparam command_t CMD_POP_RIGHT  = 3'd3;
  localparam command_t CMD_DISPLAY    = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_right;
    logic    push_left;
    logic    pop_left;
    logic    pop_right;
    logic    res_load;
    status_t res_status;
    logic    disp_start;
    logic    disp_emit;
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic disp_last;
  } deq_sts_t;

  function automatic idx_t ring_inc(input idx_t p);
    idx_t r;
    if (p == IDX_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic idx_t ring_dec(input idx_t p);
    idx_t r;
    if (p == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  // Both operands are ring positions, so one conditional subtract suffices.
  function automatic idx_t ring_add(input idx_t p, input idx_t o);
    logic [IDX_W:0] s;
    s = {1'b0, p} + {1'b0, o};
    if (s >= (IDX_W + 1)'(CAPACITY)) begin
      s = s - (IDX_W + 1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/deq_if.sv =====
// Valid/ready channel interfaces for the double-ended queue's command input and
// result output. Depends on deq_pkg.
interface deq_in_if;
  import deq_pkg::*;

  logic     valid;
  logic     ready;
  command_t command;
  element_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic     valid;
  logic     ready;
  element_t element;
  status_t  status;
  logic     last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller for the double-ended queue: decodes each accepted command and
// sequences the display stream. Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  deq_pkg::command_t in_command,
  output logic              in_ready,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        accept   = in_valid && sts.out_free;
        if (accept) begin
          case (in_command)
            CMD_PUSH_RIGHT: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.push_right = 1'b1;
              end
            end
            CMD_PUSH_LEFT: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.push_left = 1'b1;
              end
            end
            CMD_POP_LEFT: begin
              cmd.res_load = 1'b1;
              if (sts.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.pop_left = 1'b1;
              end
            end
            CMD_POP_RIGHT: begin
              cmd.res_load = 1'b1;
              if (sts.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.pop_right = 1'b1;
              end
            end
            CMD_DISPLAY: begin
              if (sts.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.disp_start = 1'b1;
                state_nxt      = S_DISP;
              end
            end
            default: begin
              // Unused codes answer with a plain ok and change nothing.
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
            end
          endcase
        end
      end
      S_DISP: begin
        if (sts.out_free) begin
          cmd.disp_emit = 1'b1;
          if (sts.disp_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/deq_dp.sv =====
// Datapath for the double-ended queue: end pointer, occupancy, display walker,
// element store and the output register. Depends on deq_pkg, deq_if and deq_ram.
module deq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_pkg::element_t in_value,
  input  deq_pkg::deq_cmd_t cmd,
  output deq_pkg::deq_sts_t sts,
  deq_out_if.source         out_ch
);
  import deq_pkg::*;

  idx_t     left_r, left_nxt;
  occ_t     occ_r, occ_nxt;
  idx_t     rd_ptr_r, rd_ptr_nxt;
  idx_t     cnt_r, cnt_nxt;
  logic     out_valid_r, out_valid_nxt;
  element_t out_element_r, out_element_nxt;
  status_t  out_status_r, out_status_nxt;
  logic     out_last_r, out_last_nxt;

  logic     ram_we;
  idx_t     ram_waddr;
  logic     ram_re;
  idx_t     ram_raddr;
  element_t ram_rdata;

  always_comb begin
    sts.full      = (occ_r == OCC_W'(CAPACITY));
    sts.empty     = (occ_r == '0);
    sts.out_free  = !out_valid_r || out_ch.ready;
    sts.disp_last = ((OCC_W'(cnt_r) + OCC_W'(1)) == occ_r);
  end

  // The right-end slot is only addressed when the store is not full, so the
  // occupancy fits a ring position there.
  assign ram_we    = cmd.push_right || cmd.push_left;
  assign ram_waddr = cmd.push_left ? ring_dec(left_r) : ring_add(left_r, occ_r[IDX_W-1:0]);
  assign ram_re    = cmd.disp_start || (cmd.disp_emit && !sts.disp_last);
  assign ram_raddr = cmd.disp_start ? left_r : rd_ptr_r;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    left_nxt        = left_r;
    occ_nxt         = occ_r;
    rd_ptr_nxt      = rd_ptr_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_element_nxt = out_element_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;

    if (cmd.push_left) begin
      left_nxt = ring_dec(left_r);
    end else if (cmd.pop_left) begin
      left_nxt = ring_inc(left_r);
    end

    if (cmd.push_right || cmd.push_left) begin
      occ_nxt = occ_r + 1'b1;
    end else if (cmd.pop_left || cmd.pop_right) begin
      occ_nxt = occ_r - 1'b1;
    end

    if (cmd.disp_start) begin
      rd_ptr_nxt = ring_inc(left_r);
      cnt_nxt    = '0;
    end else if (cmd.disp_emit) begin
      rd_ptr_nxt = ring_inc(rd_ptr_r);
      cnt_nxt    = cnt_r + 1'b1;
    end

    if (cmd.res_load) begin
      out_valid_nxt   = 1'b1;
      out_element_nxt = '0;
      out_status_nxt  = cmd.res_status;
      out_last_nxt    = 1'b1;
    end else if (cmd.disp_emit) begin
      out_valid_nxt   = 1'b1;
      out_element_nxt = ram_rdata;
      out_status_nxt  = ST_OK;
      out_last_nxt    = sts.disp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      occ_r       <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      occ_r       <= occ_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_element_r <= out_element_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.element = out_element_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.last    = out_last_r;

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Top level of the double-ended queue: a bounded deque of signed 32-bit values
// in a ring store. Depends on deq_pkg, deq_if, deq_ctrl and deq_dp.
//
// Usage:
//   in_ch carries one command per item (push right, push left, pop left,
//   pop right, display) with the value to push. out_ch carries result items:
//   element, status (ok, empty, full) and last, which marks the final result
//   of a command. Pops return their status only.
//   A push, pop or unused code gives one result, registered in the cycle after
//   the item is accepted; another item can be taken every cycle while the
//   receiver keeps up, since the output register is refilled as it drains.
//   A display of N elements gives N results: the first passes through the
//   store's registered read port and then the output register; the rest
//   follow one per cycle while the receiver keeps up, paced by that single
//   read port. Input is held off until the last element has been loaded.
//   A display or pop on an empty queue gives one empty result; a push into a
//   full queue gives one full result and the value is dropped.
//   Reset (synchronous, active low) empties the queue and the output register;
//   the store contents are not cleared, as only occupied entries are read.
//   When the receiver stalls, the pending result is held and no further item
//   is accepted until the output register can take its result.
module double_ended_queue_top (
  input logic       clk,
  input logic       rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  deq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

  // A result is only ever loaded into a free output register.
  a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load || cmd.disp_emit) |-> sts.out_free)
    else $error("result loaded while the output register was occupied");

  // No new item is taken while a display is streaming.
  a_no_accept_in_disp : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.disp_emit |-> !in_ch.ready)
    else $error("input ready during display");

  // A successful push always leaves the queue non-empty.
  a_push_fills : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_right || cmd.push_left) |=> !sts.empty)
    else $error("queue empty after a push");

  // Once a display has started, the input is held off in the following cycle.
  a_disp_start_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.disp_start |=> !in_ch.ready)
    else $error("input ready right after a display started");

endmodule
